// ----- rtl/spe_pkg.sv -----
// Shared types and constants of the shortest path engine.
// No dependencies; used by spe_edge_store and shortest_path_engine.
package spe_pkg;

  localparam int NODES       = 64;
  localparam int NODE_BITS   = $clog2(NODES);
  localparam int EDGE_BITS   = 2 * NODE_BITS;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 24;
  localparam int CNT_BITS    = NODE_BITS + 1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [1:0] REQ_DECLARE = 2'd0;
  localparam logic [1:0] REQ_EDGE    = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  typedef struct packed {
    logic                   valid;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_ent_t;

  typedef struct packed {
    logic                 en;
    logic [EDGE_BITS-1:0] addr;
    edge_ent_t            data;
  } edge_wr_t;

endpackage

// ----- rtl/spe_edge_store.sv -----
// Adjacency memory (valid flag and weight per origin/target pair).
// Runs a clearing sweep after reset and on request. Depends on spe_pkg.
module spe_edge_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr_start,
  output logic                          busy,
  input  logic                          rd_en,
  input  logic [spe_pkg::EDGE_BITS-1:0] rd_addr,
  output spe_pkg::edge_ent_t            rd_data,
  input  spe_pkg::edge_wr_t             wr
);

  spe_pkg::edge_ent_t mem [1 << spe_pkg::EDGE_BITS];
  logic [spe_pkg::EDGE_BITS-1:0] sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (clr_start) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      sweep <= sweep + 1'b1;
      if (sweep == {spe_pkg::EDGE_BITS{1'b1}}) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/shortest_path_engine.sv -----
// Shortest path engine: graph loader, Dijkstra search and path streamer.
// Depends on spe_pkg and spe_edge_store.
//
// Add edge reads the stored entry and then keeps the lower weight; clear graph
// sweeps the adjacency memory one entry per cycle (the same sweep runs after
// reset and no item is taken meanwhile). A query settles one node per round;
// each round is a scan of the distance memory for the minimum, a pick of the
// node and a pass over the node's adjacency row; predecessors are then traced
// back from the destination and the path is streamed out from the source. One
// item is worked on at a time; input is taken only when the block is idle and
// the output is empty.
module shortest_path_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // req_type[1:0], node_a[7:2], node_b[13:8], edge_cost[29:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // path_node[5:0]
  output logic        m_tuser,   // path_found
  output logic        m_tlast
);

  localparam int NB = spe_pkg::NODE_BITS;
  localparam int DB = spe_pkg::DIST_BITS;
  localparam int CB = spe_pkg::CNT_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD      = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_INIT     = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_PICK     = 4'd5;
  localparam logic [3:0] S_RELAX    = 4'd6;
  localparam logic [3:0] S_TRACE    = 4'd7;
  localparam logic [3:0] S_PRED     = 4'd8;
  localparam logic [3:0] S_EMIT_RD  = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;
  localparam logic [3:0] S_NONE     = 4'd11;
  localparam logic [3:0] S_SINGLE   = 4'd12;

  logic [3:0] state;

  logic [1:0]  in_req;
  logic [NB-1:0] in_a, in_b;
  logic [spe_pkg::WEIGHT_BITS-1:0] in_w;
  assign in_req = s_tdata[1:0];
  assign in_a   = s_tdata[7:2];
  assign in_b   = s_tdata[13:8];
  assign in_w   = s_tdata[29:14];

  logic [NB-1:0] src, dst;
  logic [spe_pkg::WEIGHT_BITS-1:0] wgt;

  logic [spe_pkg::NODES-1:0] present, settled, touched;

  logic [DB-1:0] dist_mem [spe_pkg::NODES];
  logic [NB-1:0] pred_mem [spe_pkg::NODES];
  logic [NB-1:0] path_mem [spe_pkg::NODES];
  logic [DB-1:0] dist_q;
  logic [NB-1:0] pred_q, path_q;

  logic [CB-1:0] cnt;
  logic          p_valid;
  logic [NB-1:0] p_node;
  logic [DB-1:0] best;
  logic [NB-1:0] best_node;
  logic          have;
  logic [NB-1:0] cur;
  logic [CB-1:0] len;
  logic [NB-1:0] idx;

  logic busy, accept, clr_start;
  logic edge_rd_en;
  logic [spe_pkg::EDGE_BITS-1:0] edge_rd_addr;
  spe_pkg::edge_ent_t edge_q;
  spe_pkg::edge_wr_t  edge_wr;

  assign s_tready  = (state == S_IDLE) && !m_tvalid && !busy;
  assign accept    = s_tvalid && s_tready;
  assign clr_start = accept && (in_req == spe_pkg::REQ_CLEAR);

  always_comb begin
    edge_rd_en   = 1'b0;
    edge_rd_addr = {src, cnt[NB-1:0]};
    if (accept && in_req == spe_pkg::REQ_EDGE) begin
      edge_rd_en   = 1'b1;
      edge_rd_addr = {in_a, in_b};
    end else if (state == S_RELAX && !cnt[NB]) begin
      edge_rd_en   = 1'b1;
      edge_rd_addr = {best_node, cnt[NB-1:0]};
    end
  end

  always_comb begin
    edge_wr             = '0;
    edge_wr.addr        = {src, dst};
    edge_wr.data.valid  = 1'b1;
    edge_wr.data.weight = (!edge_q.valid || wgt < edge_q.weight) ? wgt : edge_q.weight;
    edge_wr.en          = (state == S_ADD);
  end

  spe_edge_store u_edges (
    .clk       (clk),
    .rst       (rst),
    .clr_start (clr_start),
    .busy      (busy),
    .rd_en     (edge_rd_en),
    .rd_addr   (edge_rd_addr),
    .rd_data   (edge_q),
    .wr        (edge_wr)
  );

  // Pipeline stage values for the scan and relax passes
  logic [DB-1:0] cur_dist;
  logic [DB:0]   sum;
  logic [DB-1:0] nd;
  logic          scan_hit, relax_hit;
  assign cur_dist  = touched[p_node] ? dist_q : spe_pkg::DIST_MAX;
  assign scan_hit  = present[p_node] && !settled[p_node] && cur_dist < best;
  assign sum       = {1'b0, best} + {{(DB + 1 - spe_pkg::WEIGHT_BITS){1'b0}}, edge_q.weight};
  assign nd        = sum[DB] ? spe_pkg::DIST_MAX : sum[DB-1:0];
  assign relax_hit = edge_q.valid && present[p_node] && !settled[p_node] && nd < cur_dist;

  logic dist_we;
  logic [NB-1:0] dist_wa;
  logic [DB-1:0] dist_wd;
  always_comb begin
    dist_we = 1'b0;
    dist_wa = p_node;
    dist_wd = nd;
    if (state == S_INIT) begin
      dist_we = 1'b1;
      dist_wa = src;
      dist_wd = '0;
    end else if (state == S_RELAX && p_valid && relax_hit) begin
      dist_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if ((state == S_SCAN || state == S_RELAX) && !cnt[NB]) dist_q <= dist_mem[cnt[NB-1:0]];
    if (state == S_RELAX && p_valid && relax_hit) pred_mem[p_node] <= best_node;
    if (state == S_TRACE) pred_q <= pred_mem[cur];
    if (state == S_TRACE) path_mem[len[NB-1:0]] <= cur;
    if (state == S_EMIT_RD) path_q <= path_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src <= in_a;
      dst <= in_b;
      wgt <= in_w;
    end
    p_node <= cnt[NB-1:0];
    if (state == S_SCAN && p_valid && scan_hit) begin
      best      <= cur_dist;
      best_node <= p_node;
    end
    // each scan starts from the unreached distance
    if (state == S_INIT || (state == S_RELAX && cnt[NB] && !p_valid)) begin
      best <= spe_pkg::DIST_MAX;
    end
    if (state == S_PICK) cur <= dst;
    if (state == S_PRED) cur <= pred_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      present  <= '0;
      settled  <= '0;
      touched  <= '0;
      cnt      <= '0;
      p_valid  <= 1'b0;
      have     <= 1'b0;
      len      <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_req)
              spe_pkg::REQ_DECLARE: present[in_a] <= 1'b1;
              spe_pkg::REQ_EDGE:    state <= S_ADD;
              spe_pkg::REQ_CLEAR: begin
                present <= '0;
                state   <= S_CLR;
              end
              spe_pkg::REQ_QUERY: begin
                if (!present[in_a] || !present[in_b]) state <= S_NONE;
                else if (in_a == in_b)                state <= S_SINGLE;
                else                                  state <= S_INIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ADD: state <= S_IDLE;
        S_CLR: if (!busy) state <= S_IDLE;
        S_INIT: begin
          settled      <= '0;
          touched      <= {{(spe_pkg::NODES-1){1'b0}}, 1'b1} << src;
          cnt          <= '0;
          p_valid      <= 1'b0;
          have         <= 1'b0;
          state        <= S_SCAN;
        end
        S_SCAN: begin
          p_valid <= !cnt[NB];
          if (!cnt[NB]) cnt <= cnt + 1'b1;
          if (p_valid && scan_hit) have <= 1'b1;
          if (cnt[NB] && !p_valid) state <= S_PICK;
        end
        S_PICK: begin
          cnt     <= '0;
          p_valid <= 1'b0;
          len     <= '0;
          if (!have) begin
            state <= S_NONE;
          end else begin
            settled[best_node] <= 1'b1;
            if (best_node == dst) state <= S_TRACE;
            else                  state <= S_RELAX;
          end
        end
        S_RELAX: begin
          p_valid <= !cnt[NB];
          if (!cnt[NB]) cnt <= cnt + 1'b1;
          if (p_valid && relax_hit) touched[p_node] <= 1'b1;
          if (cnt[NB] && !p_valid) begin
            cnt   <= '0;
            have  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_TRACE: begin
          len <= len + 1'b1;
          if (cur == src) begin
            idx   <= len[NB-1:0];
            state <= S_EMIT_RD;
          end else begin
            state <= S_PRED;
          end
        end
        S_PRED: state <= S_TRACE;
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(8 - NB){1'b0}}, path_q};
            m_tuser  <= 1'b1;
            m_tlast  <= (idx == '0);
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        S_NONE: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_SINGLE: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(8 - NB){1'b0}}, src};
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for shortest_path_engine: drives graph loads and path queries.
// Depends on spe_pkg and the shortest_path_engine RTL; self-checking scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [spe_pkg::NODE_BITS-1:0] node;
    logic                          found;
    logic                          last;
  } path_item_t;

  class path_board;
    bit                              present [spe_pkg::NODES];
    bit                              has_edge [spe_pkg::NODES*spe_pkg::NODES];
    logic [spe_pkg::WEIGHT_BITS-1:0] weight [spe_pkg::NODES*spe_pkg::NODES];
    path_item_t                      pending [$];
    int                              errors;
    int                              results;
    int                              found_paths;

    function void wipe();
      foreach (present[i]) present[i] = 0;
      foreach (has_edge[i]) has_edge[i] = 0;
    endfunction

    function void queue_item(path_item_t it);
      pending.insert(pending.size(), it);
    endfunction

    function void push_absent();
      path_item_t it;
      it.node = '0;
      it.found = 1'b0;
      it.last = 1'b1;
      queue_item(it);
    endfunction

    function void note_input(logic [1:0] req, logic [5:0] a, logic [5:0] b,
                             logic [15:0] cost);
      logic [spe_pkg::DIST_BITS:0]   nd;
      logic [spe_pkg::DIST_BITS-1:0] dist_to [spe_pkg::NODES];
      bit                            done [spe_pkg::NODES];
      logic [5:0]                    prev [spe_pkg::NODES];
      logic [5:0]                    route [$];
      logic [spe_pkg::DIST_BITS-1:0] du;
      logic [5:0]                    cur;
      path_item_t                    it;
      int                            u;
      bit                            have;
      int                            e;
      case (req)
        spe_pkg::REQ_DECLARE: present[a] = 1;
        spe_pkg::REQ_EDGE: begin
          e = a * spe_pkg::NODES + b;
          if (!has_edge[e] || cost < weight[e]) weight[e] = cost;
          has_edge[e] = 1;
        end
        spe_pkg::REQ_CLEAR: wipe();
        default: begin
          if (!present[a] || !present[b]) begin
            push_absent();
          end else if (a == b) begin
            it.node = a;
            it.found = 1'b1;
            it.last = 1'b1;
            queue_item(it);
          end else begin
            for (int v = 0; v < spe_pkg::NODES; v++) begin
              dist_to[v] = spe_pkg::DIST_MAX;
              done[v] = 0;
              prev[v] = '0;
            end
            dist_to[a] = '0;
            for (int r = 0; r < spe_pkg::NODES; r++) begin
              have = 0;
              u = 0;
              du = spe_pkg::DIST_MAX;
              for (int v = 0; v < spe_pkg::NODES; v++)
                if (present[v] && !done[v] && dist_to[v] < du) begin
                  du = dist_to[v];
                  u = v;
                  have = 1;
                end
              if (!have) break;
              done[u] = 1;
              if (u == b) break;
              for (int v = 0; v < spe_pkg::NODES; v++) begin
                e = u * spe_pkg::NODES + v;
                if (has_edge[e] && present[v] && !done[v]) begin
                  nd = {1'b0, du} + weight[e];
                  if (nd > spe_pkg::DIST_MAX) nd = spe_pkg::DIST_MAX;
                  if (nd[spe_pkg::DIST_BITS-1:0] < dist_to[v]) begin
                    dist_to[v] = nd[spe_pkg::DIST_BITS-1:0];
                    prev[v] = 6'(u);
                  end
                end
              end
            end
            if (dist_to[b] == spe_pkg::DIST_MAX) begin
              push_absent();
            end else begin
              cur = b;
              while (route.size() < spe_pkg::NODES) begin
                route.insert(0, cur);
                if (cur == a) break;
                cur = prev[cur];
              end
              if (route[0] != a) begin
                push_absent();
              end else begin
                found_paths++;
                foreach (route[k]) begin
                  it.node = route[k];
                  it.found = 1'b1;
                  it.last = (k == route.size() - 1);
                  queue_item(it);
                end
              end
            end
          end
        end
      endcase
    endfunction

    function void check_result(path_item_t got);
      path_item_t want;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item node=%0d found=%0b last=%0b", $time,
                 got.node, got.found, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.node !== want.node) begin
        $display("%0t: path_node expected %0d actual %0d", $time, want.node, got.node);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: path_found expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: path_last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  shortest_path_engine dut (.*);

  always #5 clk = ~clk;

  path_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;
  localparam int QUIET_LIMIT = 200000;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        board.check_result('{m_tdata[5:0], m_tuser, m_tlast});
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] req, logic [5:0] a, logic [5:0] b,
                           logic [15:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {2'b00, cost, b, a, req};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(req, a, b, cost);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending.size() != 0);
  endtask

  // chain-heavy random graph over a small node set so searches find paths
  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 20)
        send_item(spe_pkg::REQ_DECLARE, 6'($urandom_range(15)), 6'($urandom),
                  16'($urandom));
      else if (r < 60)
        send_item(spe_pkg::REQ_EDGE, 6'($urandom_range(15)), 6'($urandom_range(15)),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)));
      else if (r < 97)
        send_item(spe_pkg::REQ_QUERY, 6'($urandom_range(15)), 6'($urandom_range(15)),
                  16'($urandom));
      else if (r < 98)
        send_item(spe_pkg::REQ_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
      else
        send_item(spe_pkg::REQ_QUERY, 6'($urandom), 6'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: absent nodes, self query, parallel edges, ties, maximum weights
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd63, 16'd0);
    send_item(spe_pkg::REQ_DECLARE, 6'd0, 6'd0, 16'd0);
    send_item(spe_pkg::REQ_DECLARE, 6'd63, 6'd63, 16'hffff);
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd0, 16'd0);
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd63, 16'd0);
    send_item(spe_pkg::REQ_EDGE, 6'd0, 6'd63, 16'hffff);
    send_item(spe_pkg::REQ_EDGE, 6'd0, 6'd63, 16'd500);
    send_item(spe_pkg::REQ_EDGE, 6'd0, 6'd63, 16'd900);
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd63, 16'd0);
    send_item(spe_pkg::REQ_EDGE, 6'd0, 6'd5, 16'd100);
    send_item(spe_pkg::REQ_EDGE, 6'd5, 6'd63, 16'd400);
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd63, 16'd0);
    send_item(spe_pkg::REQ_DECLARE, 6'd5, 6'd5, 16'd0);
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd63, 16'd0);
    send_item(spe_pkg::REQ_EDGE, 6'd5, 6'd63, 16'd300);
    send_item(spe_pkg::REQ_QUERY, 6'd0, 6'd63, 16'd0);
    send_item(spe_pkg::REQ_QUERY, 6'd63, 6'd0, 16'd0);
    drain();
    send_item(spe_pkg::REQ_CLEAR, 6'd0, 6'd0, 16'd0);
    for (int n = 1; n <= 3; n++) send_item(spe_pkg::REQ_DECLARE, 6'(n), 6'd0, 16'd0);
    for (int n = 1; n < 3; n++) send_item(spe_pkg::REQ_EDGE, 6'(n), 6'(n + 1), 16'hffff);
    send_item(spe_pkg::REQ_QUERY, 6'd1, 6'd3, 16'd0);
    send_item(spe_pkg::REQ_QUERY, 6'd3, 6'd1, 16'd0);
    drain();

    send_idle_pct = 26;
    recv_idle_pct = 59;
    random_phase(40);
    drain();
    send_idle_pct = 59;
    recv_idle_pct = 26;
    random_phase(40);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(35);

    drain();
    repeat (300) @(negedge clk);
    $display("sent %0d items, checked %0d result items, %0d multi-node paths",
             sent, board.results, board.found_paths);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
